// ===== sv/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

    // Character codes
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // Offsets from character code to sextet value (mod 256)
    localparam logic [7:0] OFS_UPPER = CH_UPPER_A;
    localparam logic [7:0] OFS_LOWER = 8'd71;
    localparam logic [7:0] OFS_DIGIT = 8'd252;

    localparam logic [5:0] SEXT_PLUS  = 6'd62;
    localparam logic [5:0] SEXT_SLASH = 6'd63;

    localparam int unsigned GROUP_HELD = 3;

    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } b64d_sext_t;

    // One queued job: up to three bytes plus end-of-message flag.
    // nbytes == 0 means a bare end marker.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      nbytes;
        logic            msg_end;
    } b64d_job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } b64d_qstat_t;

    function automatic b64d_sext_t b64d_map(input logic [7:0] c);
        b64d_sext_t r;
        r.ok  = 1'b1;
        r.val = '0;
        if (c inside {[CH_UPPER_A:CH_UPPER_Z]}) begin
            r.val = 6'(c - OFS_UPPER);
        end else if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            r.val = 6'(c - OFS_LOWER);
        end else if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
            r.val = 6'(c - OFS_DIGIT);
        end else if (c == CH_PLUS) begin
            r.val = SEXT_PLUS;
        end else if (c == CH_SLASH) begin
            r.val = SEXT_SLASH;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_front.sv =====
`default_nettype none

module b64d_front import b64d_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_in,
    input  wire logic        s_last_char,
    input  wire b64d_qstat_t q_stat,
    output logic             q_push,
    output b64d_job_t        q_job
);

    logic [GROUP_HELD-1:0][5:0] hold_reg, hold_next;
    logic [1:0]                 gc_reg, gc_next;
    logic                       stopped_reg, stopped_next;

    b64d_sext_t sx;
    logic       accept;
    logic       take;
    logic       full_grp;
    logic [1:0] flush_n;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;
    assign sx      = b64d_map(s_char_in);
    assign take    = !stopped_reg && sx.ok;
    assign full_grp = take && (gc_reg == 2'd3);

    always_comb begin
        hold_next    = hold_reg;
        gc_next      = gc_reg;
        stopped_next = stopped_reg;
        if (!stopped_reg && !sx.ok) begin
            stopped_next = 1'b1;
        end else if (full_grp) begin
            gc_next = '0;
        end else if (take) begin
            for (int i = 0; i < GROUP_HELD; i++) begin
                if (gc_reg == 2'(i)) begin
                    hold_next[i] = sx.val;
                end
            end
            gc_next = gc_reg + 2'd1;
        end
    end

    // partial group of n sextets flushes n-1 bytes
    assign flush_n = (gc_next >= 2'd2) ? (gc_next - 2'd1) : 2'd0;

    always_comb begin
        q_job.data[0] = {hold_next[0], hold_next[1][5:4]};
        q_job.data[1] = {hold_next[1][3:0], hold_next[2][5:2]};
        q_job.data[2] = {hold_next[2][1:0], sx.val};
        q_job.nbytes  = full_grp ? 2'd3 : (s_last_char ? flush_n : 2'd0);
        q_job.msg_end = s_last_char;
    end

    assign q_push = accept && (full_grp || s_last_char);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gc_reg      <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            if (s_last_char) begin
                gc_reg      <= '0;
                stopped_reg <= 1'b0;
            end else begin
                gc_reg      <= gc_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= hold_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
`default_nettype none

module b64d_queue import b64d_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push,
    input  wire b64d_job_t  push_job,
    input  wire logic       pop,
    output b64d_job_t       head_job,
    output b64d_qstat_t     stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    b64d_job_t       slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
`default_nettype none

module b64d_back import b64d_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire b64d_job_t   head_job,
    input  wire b64d_qstat_t q_stat,
    output logic             q_pop,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic             m_byte_valid,
    output logic             m_message_end,
    output logic             m_run_last
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       bvalid_reg, mend_reg, rlast_reg;
    logic [1:0] idx_reg;

    logic       load;
    logic [1:0] cnt;
    logic       is_last;

    // bare end marker counts as one result
    assign cnt     = (head_job.nbytes == 2'd0) ? 2'd1 : head_job.nbytes;
    assign is_last = (idx_reg == cnt - 2'd1);
    assign load    = !q_stat.empty && (!valid_reg || m_ready);
    assign q_pop   = load && is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg   <= (head_job.nbytes == 2'd0) ? 8'd0 : head_job.data[idx_reg];
            bvalid_reg <= (head_job.nbytes != 2'd0);
            mend_reg   <= is_last && head_job.msg_end;
            rlast_reg  <= is_last;
        end
    end

    assign m_valid       = valid_reg;
    assign m_data_byte   = data_reg;
    assign m_byte_valid  = bvalid_reg;
    assign m_message_end = mend_reg;
    assign m_run_last    = rlast_reg;

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder.sv =====
// Streaming base64 decoder, standard alphabet (A-Z a-z 0-9 + /).
// Input channel (s_*): one encoded character per beat; s_last_char marks
//   the final character of a message. '=' or any non-alphabet byte stops
//   decoding until the message ends; the held partial group still flushes.
// Result channel (m_*): one decoded byte per beat. m_run_last marks the last
//   beat caused by an input beat, m_message_end the last beat of a message.
//   A final character that yields no bytes produces a single end marker with
//   m_byte_valid low and m_data_byte zero.
// Timing: while s_ready is high the front end classifies and groups one character
//   per cycle and pushes byte jobs into a QUEUE_DEPTH-entry queue; the back end
//   drains one byte per cycle into the output register while the receiver takes
//   beats. A job is registered in the queue, then its first byte in the output
//   register. Sustained input rate is one beat per cycle; four characters give three bytes.
// Receiver stall: the output register holds; the queue absorbs jobs until
//   full, then s_ready drops.
// Reset (aresetn low, synchronous): queue emptied, output invalid, group
//   count and stop flag cleared.
`default_nettype none

module base64_stream_decoder import b64d_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_in,
    input  wire logic       s_last_char,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic            m_byte_valid,
    output logic            m_message_end,
    output logic            m_run_last
);

    b64d_qstat_t q_stat;
    b64d_job_t   push_job;
    b64d_job_t   head_job;
    logic        q_push;
    logic        q_pop;

    // Front: character map, group assembly, stop tracking
    b64d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_char_in   (s_char_in),
        .s_last_char (s_last_char),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    // Job queue decoupling the two sides
    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head_job (head_job),
        .stat     (q_stat)
    );

    // Back: serialize each job into byte beats
    b64d_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_job      (head_job),
        .q_stat        (q_stat),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_message_end (m_message_end),
        .m_run_last    (m_run_last)
    );

`ifndef SYNTHESIS
    // end of message always closes the run of its input beat
    a_end_is_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_message_end |-> m_run_last)
        else $error("message_end without run_last");

    // an end marker only appears as the final beat of a message
    a_marker_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_message_end && m_data_byte == 8'd0)
        else $error("end marker not at message end");

    // queue status is consistent
    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_stat.empty && q_stat.full))
        else $error("queue both empty and full");

    // input is back-pressured only by a full queue
    a_ready_tracks_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == !q_stat.full)
        else $error("s_ready does not follow queue fill");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64d_pkg::*;

    // '=' is not in the package; it is just one of the stop characters
    localparam logic [7:0] PAD_CHAR     = 8'h3D;
    localparam int         RANDOM_CHARS = 380;
    localparam int         SHOW_LIMIT   = 10;

    // One result beat as it leaves the m_* channel
    typedef struct packed {
        logic [7:0] data;
        logic       byte_ok;
        logic       msg_end;
        logic       run_last;
    } decoded_beat_t;

    // Running base64 decode of the character stream; keeps the bytes the
    // block still owes us, oldest first, and checks each result beat.
    class decode_tracker;
        logic [5:0]    held [3];
        logic [1:0]    held_cnt;
        logic          halted;
        decoded_beat_t owed_q[$];
        int            errors;
        int            bytes_seen;
        int            markers_seen;
        int            halts;

        function new();
            clear();
            errors       = 0;
            bytes_seen   = 0;
            markers_seen = 0;
            halts        = 0;
        endfunction

        function void clear();
            held[0]  = '0;
            held[1]  = '0;
            held[2]  = '0;
            held_cnt = '0;
            halted   = 1'b0;
        endfunction

        // {hit, value}; hit low for '=' and every non-alphabet byte
        function logic [6:0] sextet_of(logic [7:0] c);
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return {1'b1, 6'(c - CH_UPPER_A)};
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return {1'b1, 6'(c - CH_LOWER_A + 26)};
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return {1'b1, 6'(c - CH_DIGIT_0 + 52)};
            if (c == CH_PLUS)  return {1'b1, 6'd62};
            if (c == CH_SLASH) return {1'b1, 6'd63};
            return 7'd0;
        endfunction

        // Accepted input beat; returns 1 if the character was not ignored or ends the message
        function bit take_char(logic [7:0] c, logic last);
            decoded_beat_t made[$];
            logic [6:0]    sx;
            bit            live;
            live = !halted;
            if (!halted) begin
                sx = sextet_of(c);
                if (!sx[6]) begin
                    halted = 1'b1;
                    halts++;
                end else if (held_cnt == 2'd3) begin
                    made.push_back('{{held[0], held[1][5:4]}, 1'b1, 1'b0, 1'b0});
                    made.push_back('{{held[1][3:0], held[2][5:2]}, 1'b1, 1'b0, 1'b0});
                    made.push_back('{{held[2][1:0], sx[5:0]}, 1'b1, 1'b0, 1'b0});
                    held_cnt = '0;
                end else begin
                    held[held_cnt] = sx[5:0];
                    held_cnt++;
                end
            end
            if (last) begin
                // flush: n held sextets give n-1 bytes
                if (held_cnt >= 2)
                    made.push_back('{{held[0], held[1][5:4]}, 1'b1, 1'b0, 1'b0});
                if (held_cnt == 3)
                    made.push_back('{{held[1][3:0], held[2][5:2]}, 1'b1, 1'b0, 1'b0});
                if (made.size() == 0)
                    made.push_back('{8'h00, 1'b0, 1'b0, 1'b0});
                made[made.size() - 1].msg_end = 1'b1;
                clear();
                live = 1'b1;
            end
            if (made.size() > 0)
                made[made.size() - 1].run_last = 1'b1;
            foreach (made[i])
                owed_q.push_back(made[i]);
            return live;
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= SHOW_LIMIT)
                $display("[%0t] MISMATCH %s", $time, msg);
        endfunction

        // Accepted result beat
        function void match_byte(decoded_beat_t got);
            decoded_beat_t want;
            if (owed_q.size() == 0) begin
                complain($sformatf("unexpected beat data=%02h byte_valid=%0b end=%0b run_last=%0b",
                                   got.data, got.byte_ok, got.msg_end, got.run_last));
                return;
            end
            want = owed_q.pop_front();
            if (want.byte_ok) bytes_seen++;
            else markers_seen++;
            if (got.data != want.data || got.byte_ok != want.byte_ok ||
                got.msg_end != want.msg_end || got.run_last != want.run_last)
                complain($sformatf(
                    "exp data=%02h bv=%0b end=%0b rl=%0b, got data=%02h bv=%0b end=%0b rl=%0b",
                    want.data, want.byte_ok, want.msg_end, want.run_last,
                    got.data, got.byte_ok, got.msg_end, got.run_last));
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_last_char;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_data_byte;
    logic       m_byte_valid;
    logic       m_message_end;
    logic       m_run_last;

    decode_tracker tracker = new();

    // sender pacing: gap before the next char is drawn right after each accept
    int next_gap;
    bit s_quiet;
    int chars_sent;
    int chars_live;
    int messages;
    bit mid_drained;

    base64_stream_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_char_in     (s_char_in),
        .s_last_char   (s_last_char),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data_byte   (m_data_byte),
        .m_byte_valid  (m_byte_valid),
        .m_message_end (m_message_end),
        .m_run_last    (m_run_last)
    );

    // 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] char_for(int unsigned s);
        if (s < 26) return CH_UPPER_A + 8'(s);
        if (s < 52) return CH_LOWER_A + 8'(s - 26);
        if (s < 62) return CH_DIGIT_0 + 8'(s - 52);
        if (s == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    // Entered at a falling edge. Valid is only lowered when a gap follows,
    // so back-to-back beats never see a low/high pair in one step.
    task automatic send_char(input logic [7:0] c, input logic last);
        repeat (next_gap) @(negedge aclk);
        s_valid     <= 1'b1;
        s_char_in   <= c;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (tracker.take_char(c, last)) chars_live++;
        chars_sent++;
        if (last) messages++;
        @(negedge aclk);
        next_gap = draw_gap(s_quiet);
        if (next_gap > 0) s_valid <= 1'b0;
    endtask

    // Hold the sender off until the block has caught up completely;
    // valid is still high only when no gap was drawn after the last beat
    task automatic drain_wait();
        if (next_gap == 0) s_valid <= 1'b0;
        do @(negedge aclk); while (tracker.outstanding() != 0);
    endtask

    // Random message: mostly valid base64 with optional padding and junk
    // after it; the rest raw bytes that may stop decoding somewhere.
    task automatic send_message();
        int          len;
        int          pads;
        int          junk;
        int          total;
        int          k;
        logic [7:0]  text[$];
        s_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) != 0) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 10);
            for (k = 0; k < len; k++)
                text.push_back(char_for($urandom_range(0, 63)));
            pads = $urandom_range(0, 2);
            for (k = 0; k < pads; k++)
                text.push_back(PAD_CHAR);
            junk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
            for (k = 0; k < junk; k++)
                text.push_back(8'($urandom_range(0, 255)));
        end else begin
            len = $urandom_range(1, 8);
            for (k = 0; k < len; k++)
                text.push_back(8'($urandom_range(0, 255)));
        end
        if (text.size() == 0)
            text.push_back(8'($urandom_range(0, 255)));
        total = text.size();
        for (k = 0; k < total; k++)
            send_char(text[k], k == total - 1);
    endtask

    // Result side: random stalls, with quiet stretches of no stall at all
    initial begin
        int            gap;
        int            quiet_left;
        bit            r_quiet;
        decoded_beat_t got;
        m_ready    = 1'b0;
        r_quiet    = 1'b0;
        quiet_left = $urandom_range(20, 60);
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        @(negedge aclk);
        forever begin
            if (--quiet_left <= 0) begin
                r_quiet    = !r_quiet;
                quiet_left = $urandom_range(20, 60);
            end
            gap = draw_gap(r_quiet);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got = '{m_data_byte, m_byte_valid, m_message_end, m_run_last};
            tracker.match_byte(got);
            @(negedge aclk);
        end
    end

    // Watchdog, far beyond the slowest legal run
    initial begin
        #2ms;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        s_valid     = 1'b0;
        s_char_in   = 8'h00;
        s_last_char = 1'b0;
        aresetn     = 1'b0;
        chars_sent  = 0;
        chars_live  = 0;
        messages    = 0;
        mid_drained = 1'b0;
        s_quiet     = 1'b0;
        next_gap    = draw_gap(s_quiet);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed ---
        // alphabet range ends, full group landing on the final char
        send_char(CH_UPPER_A, 1'b0);
        send_char(CH_LOWER_Z, 1'b0);
        send_char(CH_DIGIT_0, 1'b0);
        send_char(CH_DIGIT_9, 1'b1);
        // '+' '/', then '=' stops; the byte after the stop is ignored,
        // two held sextets still flush one byte
        send_char(CH_PLUS, 1'b0);
        send_char(CH_SLASH, 1'b0);
        send_char(PAD_CHAR, 1'b0);
        send_char(8'hFF, 1'b1);
        // lone stop char as the whole message -> bare end marker
        send_char(8'h00, 1'b1);
        // three sextets flush as two bytes
        send_char(CH_UPPER_Z, 1'b0);
        send_char(CH_LOWER_A, 1'b0);
        send_char("D", 1'b1);
        // single sextet: nothing to flush, end marker only
        send_char("z", 1'b1);
        // one sextet, stop, ignored final char
        send_char("9", 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'h7F, 1'b1);
        // full group mid-message, then two extra sextets, the second on the final char
        repeat (5) send_char(CH_SLASH, 1'b0);
        send_char(CH_SLASH, 1'b1);

        // pause the sender until every owed beat is out
        drain_wait();

        // --- random ---
        while (chars_sent < RANDOM_CHARS) begin
            send_message();
            if (!mid_drained && chars_sent >= 200) begin
                drain_wait();
                mid_drained = 1'b1;
            end
        end
        if (next_gap == 0) s_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        $display("Decoded %0d messages from %0d chars (%0d stops): %0d bytes, %0d end markers.",
                 messages, chars_sent, tracker.halts, tracker.bytes_seen, tracker.markers_seen);
        $display("Mismatches: %0d", tracker.errors);
        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
